### rtl/xcpc_pkg.sv
// shared types and constants for the xor checksum packet codec
`timescale 1ns / 1ps

package xcpc_pkg;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
    localparam logic [POS_W-1:0] HDR_LEN = 17'd5;
    localparam logic [POS_W-1:0] HDR_CODE_POS = 17'd3;
    localparam logic [POS_W-1:0] HDR_CHECK_POS = 17'd4;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_HEADER_CODE = 2'd1;
    localparam logic [1:0] REG_SCRAMBLE_CONSTANT = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd9995;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
        logic [7:0] random_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        out_last;
        logic [7:0]  hdr_code;
        logic [15:0] payload_length;
        logic [7:0]  scramble_code;
        logic [7:0]  checksum_byte;
        logic        checksum_ok;
        logic        overflow;
    } t_out_item;

    typedef struct packed {
        logic        direction;
        logic [7:0]  header_code;
        logic [7:0]  scramble_constant;
        logic [15:0] max_payload;
        logic        clear_packet;
    } t_cfg;

endpackage

### rtl/xcpc_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module xcpc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xcpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output xcpc_pkg::t_cfg              o_cfg
);

    logic        r_direction;
    logic [7:0]  r_header_code;
    logic [7:0]  r_scramble_constant;
    logic [15:0] r_max_payload;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction         <= xcpc_pkg::DIR_ENCODE;
            r_header_code       <= 8'd0;
            r_scramble_constant <= 8'd0;
            r_max_payload       <= xcpc_pkg::MAX_PAYLOAD_RESET;
        end else begin
            if (wr_en) begin
                case (reg_sel)
                    xcpc_pkg::REG_DIRECTION:         r_direction <= pwdata[0];
                    xcpc_pkg::REG_HEADER_CODE:       r_header_code <= pwdata[7:0];
                    xcpc_pkg::REG_SCRAMBLE_CONSTANT: r_scramble_constant <= pwdata[7:0];
                    xcpc_pkg::REG_MAX_PAYLOAD:       r_max_payload <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_sel)
            xcpc_pkg::REG_DIRECTION:         prdata = {31'd0, r_direction};
            xcpc_pkg::REG_HEADER_CODE:       prdata = {24'd0, r_header_code};
            xcpc_pkg::REG_SCRAMBLE_CONSTANT: prdata = {24'd0, r_scramble_constant};
            xcpc_pkg::REG_MAX_PAYLOAD:       prdata = {16'd0, r_max_payload};
            default:                         prdata = 32'd0;
        endcase
    end

    assign o_cfg.direction         = r_direction;
    assign o_cfg.header_code       = r_header_code;
    assign o_cfg.scramble_constant = r_scramble_constant;
    assign o_cfg.max_payload       = r_max_payload;
    // packet state clears at the same edge that writes the direction
    assign o_cfg.clear_packet      = wr_en && (reg_sel == xcpc_pkg::REG_DIRECTION);

endmodule

### rtl/xcpc_core.sv
// per-item scramble, checksum and header logic with packet state
`timescale 1ns / 1ps

module xcpc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xcpc_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  xcpc_pkg::t_in_item   i_item,
    output logic                 o_res_valid,
    output xcpc_pkg::t_out_item  o_res
);

    logic [xcpc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_sum, n_sum;
    logic [7:0]                 r_code, n_code;
    logic [7:0]                 r_check, n_check;
    logic                       r_ovf, n_ovf;

    logic [xcpc_pkg::POS_W-1:0] pos_inc;
    logic [xcpc_pkg::POS_W-1:0] count;
    logic [7:0]                 data_byte;
    logic [xcpc_pkg::POS_W-1:0] max_ext;
    logic                       in_header;

    assign pos_inc   = (r_pos < xcpc_pkg::POS_MAX) ? r_pos + 1'b1 : r_pos;
    assign max_ext   = {1'b0, i_cfg.max_payload};
    assign in_header = (r_pos < xcpc_pkg::HDR_LEN);

    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_code      = r_code;
        n_check     = r_check;
        n_ovf       = r_ovf;
        o_res_valid = 1'b0;
        o_res       = '0;
        count       = pos_inc;
        data_byte   = i_item.in_byte;

        if (i_cfg.direction == xcpc_pkg::DIR_ENCODE) begin
            if (r_pos == '0) begin
                n_code = i_item.random_byte ^ i_cfg.scramble_constant;
            end
            n_sum       = r_sum + i_item.in_byte;
            n_pos       = pos_inc;
            n_ovf       = r_ovf | (pos_inc > max_ext);
            o_res_valid = 1'b1;
            o_res.out_byte      = i_item.in_byte ^ n_code;
            o_res.byte_valid    = 1'b1;
            o_res.out_last      = i_item.in_last;
            o_res.scramble_code = n_code;
            o_res.overflow      = n_ovf;
            if (i_item.in_last) begin
                o_res.hdr_code       = i_cfg.header_code;
                o_res.payload_length = pos_inc[16] ? xcpc_pkg::LEN_MAX : pos_inc[15:0];
                o_res.checksum_byte  = n_sum ^ n_code;
            end
        end else if (in_header) begin
            // header bytes: only the scramble code and the checksum are kept
            if (r_pos == xcpc_pkg::HDR_CODE_POS) begin
                n_code = i_item.in_byte;
            end
            if (r_pos == xcpc_pkg::HDR_CHECK_POS) begin
                n_check = i_item.in_byte;
            end
            n_pos = r_pos + 1'b1;
            if (i_item.in_last) begin
                o_res_valid         = 1'b1;
                o_res.out_last      = 1'b1;
                o_res.scramble_code = n_code;
                o_res.checksum_byte = n_check;
                o_res.checksum_ok   = (n_pos == xcpc_pkg::HDR_LEN) && (n_check == n_code);
            end
        end else begin
            data_byte   = i_item.in_byte ^ r_code;
            n_sum       = r_sum + data_byte;
            n_pos       = pos_inc;
            count       = pos_inc - xcpc_pkg::HDR_LEN;
            n_ovf       = r_ovf | (count > max_ext);
            o_res_valid = 1'b1;
            o_res.out_byte      = data_byte;
            o_res.byte_valid    = 1'b1;
            o_res.out_last      = i_item.in_last;
            o_res.scramble_code = r_code;
            o_res.overflow      = n_ovf;
            if (i_item.in_last) begin
                o_res.payload_length = count[16] ? xcpc_pkg::LEN_MAX : count[15:0];
                o_res.checksum_byte  = r_check;
                o_res.checksum_ok    = ((r_check ^ r_code) == n_sum);
            end
        end

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear_packet) begin
            r_pos   <= '0;
            r_sum   <= 8'd0;
            r_code  <= 8'd0;
            r_check <= 8'd0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_item.in_last) begin
                r_pos   <= '0;
                r_sum   <= 8'd0;
                r_code  <= 8'd0;
                r_check <= 8'd0;
                r_ovf   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_code  <= n_code;
                r_check <= n_check;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

### rtl/xcpc_outbuf.sv
// result register with a skid stage toward the output channel
`timescale 1ns / 1ps

module xcpc_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  xcpc_pkg::t_out_item  i_res,
    output logic                 o_space,
    output logic                 o_skid_full,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output xcpc_pkg::t_out_item  o_out_item
);

    logic                r_out_valid;
    xcpc_pkg::t_out_item r_out;
    logic                r_skid_valid;
    xcpc_pkg::t_out_item r_skid;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    // no new item while the skid stage holds a result
    assign o_space     = !r_skid_valid;
    assign o_skid_full = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/xor_checksum_packet_codec.sv
// top level of the xor checksum packet codec
`timescale 1ns / 1ps

// Byte-stream packet codec: encode scrambles payload bytes with a per-packet
// code and appends header fields on the last result; decode strips a 5-byte
// header and descrambles and checks the payload. One item is taken per clock
// while the skid stage is empty: the scramble, 8-bit checksum add and length
// count sit between the input port and a result register, and a skid stage
// behind it keeps the input open for one more item while a result waits.
// Decode header bytes other than a frame's last byte give no result. Users are
// to write configuration through the apb-style port while idle; not enforced.
module xor_checksum_packet_codec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  xcpc_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output xcpc_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xcpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    xcpc_pkg::t_cfg      cfg;
    xcpc_pkg::t_out_item res;
    logic                res_valid;
    logic                accept;
    logic                skid_full;

    assign accept = i_in_valid & o_in_ready;

    xcpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    xcpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xcpc_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (o_in_ready),
        .o_skid_full (skid_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && res_valid) |=> skid_full)
        else $error("result produced during a stall was not kept in the skid stage");

    a_headerless_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.byte_valid) |-> o_out_item.out_last)
        else $error("result without a payload byte must close the frame");

    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> accept)
        else $error("result produced without an accepted item");

endmodule

### dv/tb_xor_checksum_packet_codec.sv
// testbench for the xor checksum packet codec: directed and random traffic checked against a predictor
`timescale 1ns / 1ps

module tb_xor_checksum_packet_codec;

    localparam logic DIR_DECODE = ~xcpc_pkg::DIR_ENCODE;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 90;
    localparam int unsigned LONG_PACKET = 48;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    xcpc_pkg::t_in_item            i_in_item = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    xcpc_pkg::t_out_item           o_out_item;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [xcpc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // predictor copy of the configuration and the packet state
    logic                          cfg_dir = xcpc_pkg::DIR_ENCODE;
    logic [7:0]                    cfg_hdr_code = 8'h00;
    logic [7:0]                    cfg_scr_const = 8'h00;
    logic [15:0]                   cfg_max_len = xcpc_pkg::MAX_PAYLOAD_RESET;
    logic [xcpc_pkg::POS_W-1:0]    pkt_pos = '0;
    logic [7:0]                    pkt_sum = 8'h00;
    logic [7:0]                    pkt_code = 8'h00;
    logic [7:0]                    pkt_check = 8'h00;
    logic                          pkt_overflow = 1'b0;

    xcpc_pkg::t_out_item           expected_results[$];
    xcpc_pkg::t_out_item           want_item;
    int unsigned                   mismatch_count = 0;
    int unsigned                   items_sent = 0;
    int unsigned                   cycle_count = 0;
    int unsigned                   burst_left = 0;
    bit                            gaps_on = 1'b1;
    logic [1:0]                    stall_mode = 2'd0;
    int unsigned                   stall_left = 0;

    xor_checksum_packet_codec DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: switches between always ready, light and heavy random stalls and a fixed pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (cycle_count[3:0] < 4'd11);
        endcase
    end

    function automatic logic [15:0] saturate_len(input logic [xcpc_pkg::POS_W-1:0] n);
        return (n > {1'b0, xcpc_pkg::LEN_MAX}) ? xcpc_pkg::LEN_MAX : n[15:0];
    endfunction

    function automatic void clear_packet_state();
        pkt_pos = '0;
        pkt_sum = 8'h00;
        pkt_code = 8'h00;
        pkt_check = 8'h00;
        pkt_overflow = 1'b0;
    endfunction

    // returns 1 when the item produces a result
    function automatic bit predict_codec(input xcpc_pkg::t_in_item it,
                                         output xcpc_pkg::t_out_item res);
        logic [xcpc_pkg::POS_W-1:0] payload_cnt;
        res = '0;
        if (cfg_dir == xcpc_pkg::DIR_ENCODE) begin
            if (pkt_pos == '0) pkt_code = it.random_byte ^ cfg_scr_const;
            pkt_sum = pkt_sum + it.in_byte;
            if (pkt_pos < xcpc_pkg::POS_MAX) pkt_pos = pkt_pos + 1'b1;
            if (pkt_pos > {1'b0, cfg_max_len}) pkt_overflow = 1'b1;
            res.out_byte = it.in_byte ^ pkt_code;
            res.byte_valid = 1'b1;
            res.out_last = it.in_last;
            res.scramble_code = pkt_code;
            res.overflow = pkt_overflow;
            if (it.in_last) begin
                res.hdr_code = cfg_hdr_code;
                res.payload_length = saturate_len(pkt_pos);
                res.checksum_byte = pkt_sum ^ pkt_code;
                clear_packet_state();
            end
            return 1'b1;
        end
        if (pkt_pos < xcpc_pkg::HDR_LEN) begin
            if (pkt_pos == xcpc_pkg::HDR_CODE_POS) pkt_code = it.in_byte;
            else if (pkt_pos == xcpc_pkg::HDR_CHECK_POS) pkt_check = it.in_byte;
            pkt_pos = pkt_pos + 1'b1;
            if (!it.in_last) return 1'b0;
            // frame ended inside the header
            res.out_last = 1'b1;
            res.scramble_code = pkt_code;
            res.checksum_byte = pkt_check;
            res.checksum_ok = (pkt_pos == xcpc_pkg::HDR_LEN) &&
                              ((pkt_check ^ pkt_code) == 8'h00);
            clear_packet_state();
            return 1'b1;
        end
        res.out_byte = it.in_byte ^ pkt_code;
        pkt_sum = pkt_sum + res.out_byte;
        if (pkt_pos < xcpc_pkg::POS_MAX) pkt_pos = pkt_pos + 1'b1;
        payload_cnt = pkt_pos - xcpc_pkg::HDR_LEN;
        if (payload_cnt > {1'b0, cfg_max_len}) pkt_overflow = 1'b1;
        res.byte_valid = 1'b1;
        res.out_last = it.in_last;
        res.scramble_code = pkt_code;
        res.overflow = pkt_overflow;
        if (it.in_last) begin
            res.payload_length = saturate_len(payload_cnt);
            res.checksum_byte = pkt_check;
            res.checksum_ok = ((pkt_check ^ pkt_code) == pkt_sum);
            clear_packet_state();
        end
        return 1'b1;
    endfunction

    task automatic report_field(input string fname, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result expected none actual %h", $time, o_out_item);
            end else begin
                want_item = expected_results.pop_front();
                report_field("out_byte", want_item.out_byte, o_out_item.out_byte);
                report_field("byte_valid", want_item.byte_valid, o_out_item.byte_valid);
                report_field("out_last", want_item.out_last, o_out_item.out_last);
                report_field("hdr_code", want_item.hdr_code, o_out_item.hdr_code);
                report_field("payload_length", want_item.payload_length,
                             o_out_item.payload_length);
                report_field("scramble_code", want_item.scramble_code,
                             o_out_item.scramble_code);
                report_field("checksum_byte", want_item.checksum_byte,
                             o_out_item.checksum_byte);
                report_field("checksum_ok", want_item.checksum_ok, o_out_item.checksum_ok);
                report_field("overflow", want_item.overflow, o_out_item.overflow);
            end
        end
    end

    function automatic xcpc_pkg::t_in_item mk_item(input logic [7:0] b, input logic last,
                                                   input logic [7:0] rnd);
        xcpc_pkg::t_in_item it;
        it.in_byte = b;
        it.in_last = last;
        it.random_byte = rnd;
        return it;
    endfunction

    // bursts of random length, then a short gap unless gaps are off
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_item(input xcpc_pkg::t_in_item it);
        xcpc_pkg::t_out_item res;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (predict_codec(it, res)) expected_results.push_back(res);
        pace_sender();
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // header bytes may still be in flight with no result behind them
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] regsel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (regsel)
            xcpc_pkg::REG_DIRECTION: begin
                cfg_dir = value[0];
                clear_packet_state();
            end
            xcpc_pkg::REG_HEADER_CODE: cfg_hdr_code = value[7:0];
            xcpc_pkg::REG_SCRAMBLE_CONSTANT: cfg_scr_const = value[7:0];
            default: cfg_max_len = value[15:0];
        endcase
    endtask

    task automatic send_encode_packet(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(mk_item(8'($urandom), i == len - 1, 8'($urandom)));
    endtask

    task automatic send_short_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(mk_item(8'($urandom), i == len - 1, 8'($urandom)));
    endtask

    // well-formed frame: random code and payload, checksum matching unless corrupted
    task automatic send_decode_frame(input int unsigned plen, input bit bad_check);
        logic [7:0] frame_bytes[$];
        logic [7:0] code;
        logic [7:0] sum;
        logic [7:0] plain;
        logic [7:0] chk;
        code = 8'($urandom);
        sum = 8'h00;
        frame_bytes = {8'($urandom), 8'($urandom), 8'($urandom), code, 8'h00};
        for (int unsigned i = 0; i < plen; i++) begin
            plain = 8'($urandom);
            sum = sum + plain;
            frame_bytes.push_back(plain ^ code);
        end
        chk = sum ^ code;
        if (bad_check) chk = chk ^ (8'h01 << $urandom_range(0, 7));
        frame_bytes[4] = chk;
        foreach (frame_bytes[i])
            send_item(mk_item(frame_bytes[i], i == frame_bytes.size() - 1, 8'($urandom)));
    endtask

    task automatic test_encode_directed();
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(xcpc_pkg::DIR_ENCODE));
        cfg_write(xcpc_pkg::REG_HEADER_CODE, 32'hA5);
        cfg_write(xcpc_pkg::REG_SCRAMBLE_CONSTANT, 32'h00);
        send_item(mk_item(8'h00, 1'b1, 8'h00));
        send_item(mk_item(8'hFF, 1'b1, 8'hFF));
        drain_results();
        cfg_write(xcpc_pkg::REG_SCRAMBLE_CONSTANT, 32'hFF);
        cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'd1);
        // overflow from the second byte on; random byte ignored after the first
        send_item(mk_item(8'hFF, 1'b0, 8'h5A));
        send_item(mk_item(8'h80, 1'b0, 8'hC3));
        send_item(mk_item(8'h01, 1'b1, 8'h3C));
        drain_results();
        cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'd0);
        send_item(mk_item(8'h7E, 1'b1, 8'h81));
    endtask

    task automatic test_decode_directed();
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(DIR_DECODE));
        cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'd1);
        send_short_frame(1);
        send_short_frame(4);
        send_decode_frame(0, 1'b0);
        send_decode_frame(0, 1'b1);
        send_decode_frame(2, 1'b0);
    endtask

    task automatic test_direction_clear();
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(xcpc_pkg::DIR_ENCODE));
        cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'd9995);
        send_item(mk_item(8'h11, 1'b0, 8'h22));
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(xcpc_pkg::DIR_ENCODE));
        // new packet: code comes from this random byte
        send_item(mk_item(8'h33, 1'b1, 8'h44));
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(DIR_DECODE));
        repeat (4) send_item(mk_item(8'($urandom), 1'b0, 8'($urandom)));
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(DIR_DECODE));
        send_decode_frame(1, 1'b0);
    endtask

    // packets well past the payload limit, sent with no gaps
    task automatic test_long_packets();
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(xcpc_pkg::DIR_ENCODE));
        cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'd32);
        gaps_on = 1'b0;
        send_encode_packet(LONG_PACKET);
        drain_results();
        cfg_write(xcpc_pkg::REG_DIRECTION, 32'(DIR_DECODE));
        send_decode_frame(LONG_PACKET, 1'b0);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned sel;
        logic [7:0] hdr;
        logic [7:0] scr;
        logic [15:0] max_len;
        bit paused;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            hdr = (phase == 0) ? 8'h00 : (phase == 2) ? 8'hFF : 8'($urandom);
            scr = (phase == 4) ? 8'h00 : (phase == 6) ? 8'hFF : 8'($urandom);
            case (phase)
                0: max_len = 16'd1;
                1, 4: max_len = 16'hFFFF;
                2, 3: max_len = 16'($urandom_range(2, 12));
                5: max_len = 16'd0;
                6: max_len = 16'($urandom_range(13, 40));
                default: max_len = 16'($urandom);
            endcase
            cfg_write(xcpc_pkg::REG_DIRECTION,
                      32'(phase[0] ? DIR_DECODE : xcpc_pkg::DIR_ENCODE));
            cfg_write(xcpc_pkg::REG_HEADER_CODE, 32'(hdr));
            cfg_write(xcpc_pkg::REG_SCRAMBLE_CONSTANT, 32'(scr));
            cfg_write(xcpc_pkg::REG_MAX_PAYLOAD, 32'(max_len));
            gaps_on = (phase % 3 != 2);
            paused = 1'b0;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                sel = $urandom_range(0, 9);
                if (cfg_dir == xcpc_pkg::DIR_ENCODE) begin
                    send_encode_packet(sel == 0 ? $urandom_range(25, 60) : $urandom_range(1, 24));
                end else if (sel == 0) begin
                    send_short_frame($urandom_range(1, 4));
                end else begin
                    send_decode_frame($urandom_range(0, 24), sel == 1);
                end
                // hold off until the block has emptied, once per phase
                if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encode_directed();
        test_decode_directed();
        test_direction_clear();
        test_random_traffic();
        test_long_packets();
        drain_results();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
